[hdl/ftsp_pkg.sv]
// Shared types, constants and command codes for the fixed-time signal plan sequencer.
// No dependencies.
package ftsp_pkg;

  localparam int MAX_PLANS_DEF  = 8;
  localparam int MAX_STEPS_DEF  = 16;
  localparam int MAX_PHASES_DEF = 16;
  localparam int MAX_MOVES_DEF  = 16;
  localparam logic [14:0] ID_CEILING = 15'd32767;

  typedef enum logic [2:0] {
    CMD_ADD_PLAN  = 3'd0,
    CMD_ADD_STEP  = 3'd1,
    CMD_ADD_PHASE = 3'd2,
    CMD_ADD_MOVE  = 3'd3,
    CMD_BEGIN     = 3'd4,
    CMD_TICK      = 3'd5,
    CMD_SET_PLAN  = 3'd6,
    CMD_CHECK     = 3'd7
  } cmd_t;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_NO_PLAN  = 3'd1;
  localparam logic [2:0] ERR_NO_PHASE = 3'd2;
  localparam logic [2:0] ERR_NO_STEP  = 3'd3;
  localparam logic [2:0] ERR_FULL     = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [14:0] plan_value;
    logic [15:0] step_start;
    logic [15:0] step_end;
    logic [3:0]  phase_number;
    logic [9:0]  from_set;
    logic [9:0]  to_set;
  } item_t;

  typedef struct packed {
    logic [3:0]  slot_index;
    logic        allowed;
    logic [2:0]  error;
    logic [2:0]  current_plan;
    logic [3:0]  current_phase;
    logic [4:0]  current_step;
    logic [16:0] countdown;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // latch the item and run the part that needs no scan or step read
    logic scan_clr;   // zero the scan index
    logic scan_step;  // examine one entry and advance
    logic load_req;   // read the step memory at the current position
    logic load_fin;   // apply the step read
    logic finish;     // drive the result strobe
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_scan;  // item needs a table scan
    logic need_load;  // item (after scan) needs a step load
    logic scan_done;  // last entry examined this cycle
  } sts_t;

endpackage

[hdl/fixed_time_signal_plan_sequencer.sv]
// Top level of the fixed-time signal plan sequencer.
// Depends on ftsp_pkg, ftsp_control and ftsp_datapath.
//
// Channel   Ports                     Transaction
// input     start, busy, item         accepted when start is high and busy is low
// result    done, result              valid for the one cycle that done is high
//
// Every transaction yields one result. A transaction that needs no scan and no
// step read passes through a decide state to the done state, and the next one
// can be accepted once busy falls. Set plan scans the plan table (at least one
// scan step), begin scans it and then reads and applies the step, a tick that
// ends a step reads and applies the step, and a move check scans the stored
// moves with one extra step to compare the last entry read. Reset clears all
// counts and the running state. The receiver cannot stall; busy stays high
// through the done cycle.
module fixed_time_signal_plan_sequencer #(
  parameter int MAX_PLANS  = ftsp_pkg::MAX_PLANS_DEF,
  parameter int MAX_STEPS  = ftsp_pkg::MAX_STEPS_DEF,
  parameter int MAX_PHASES = ftsp_pkg::MAX_PHASES_DEF,
  parameter int MAX_MOVES  = ftsp_pkg::MAX_MOVES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ftsp_pkg::item_t   item,
  output logic              done,
  output ftsp_pkg::result_t result
);
  import ftsp_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The controller sequences each transaction; the datapath holds all tables.
  ftsp_control u_control (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .ctl   (ctl)
  );

  ftsp_datapath #(
    .MAX_PLANS  (MAX_PLANS),
    .MAX_STEPS  (MAX_STEPS),
    .MAX_PHASES (MAX_PHASES),
    .MAX_MOVES  (MAX_MOVES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .sts    (sts),
    .result (result)
  );

endmodule

[hdl/ftsp_datapath.sv]
// Datapath of the signal plan sequencer: tables, running state and scans.
// Depends on ftsp_pkg.
module ftsp_datapath #(
  parameter int MAX_PLANS  = ftsp_pkg::MAX_PLANS_DEF,
  parameter int MAX_STEPS  = ftsp_pkg::MAX_STEPS_DEF,
  parameter int MAX_PHASES = ftsp_pkg::MAX_PHASES_DEF,
  parameter int MAX_MOVES  = ftsp_pkg::MAX_MOVES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ftsp_pkg::item_t   item,
  input  ftsp_pkg::ctl_t    ctl,
  output ftsp_pkg::sts_t    sts,
  output ftsp_pkg::result_t result
);
  import ftsp_pkg::*;

  localparam int PW  = $clog2(MAX_PLANS + 1);
  localparam int PI  = (MAX_PLANS > 1) ? $clog2(MAX_PLANS) : 1;
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int HW  = $clog2(MAX_PHASES + 1);
  localparam int HI  = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int MW  = $clog2(MAX_MOVES + 1);
  localparam int MI  = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
  localparam int SD  = MAX_PLANS * MAX_STEPS;
  localparam int SA  = (SD > 1) ? $clog2(SD) : 1;
  localparam int MD  = MAX_PHASES * MAX_MOVES;
  localparam int MA  = (MD > 1) ? $clog2(MD) : 1;
  localparam int XW  = (PW > MW) ? PW : MW;

  // Tables.
  logic [14:0] plan_ids    [MAX_PLANS];
  logic [SW-1:0] step_counts [MAX_PLANS];
  logic [MW-1:0] move_counts [MAX_PHASES];
  logic [16:0] step_len_mem [SD];
  logic [HI-1:0] step_ph_mem [SD];
  logic [19:0] move_mem [MD];
  logic [PW-1:0] plan_count;
  logic [HW-1:0] phase_count;

  // Running state.
  logic [PI-1:0] running_plan;
  logic [HI-1:0] shown_phase;
  logic [4:0]    step_position;
  logic [16:0]   ticks_left;

  // Per-item working registers.
  item_t       cur;
  logic [2:0]  err;
  logic [3:0]  slot;
  logic        allowed;
  logic        load_pend;
  logic        scan_pend;
  logic [XW-1:0] scan_idx;
  logic [14:0] best;
  logic [16:0] rd_len;
  logic [HI-1:0] rd_ph;
  logic [19:0] mv_rd;
  logic        mv_v;

  cmd_t icmd, ccmd;
  assign icmd = cmd_t'(item.cmd);
  assign ccmd = cmd_t'(cur.cmd);

  logic [16:0] length_in;
  assign length_in = (item.step_end > item.step_start)
                   ? {1'b0, item.step_end - item.step_start} + 17'd1
                   : {1'b0, item.step_start - item.step_end} + 17'd1;

  logic [19:0] key;
  assign key = {cur.from_set, cur.to_set};

  // Plan-index wide compare helpers.
  logic plan_ok_item, ph_ok_item, run_ok;
  assign plan_ok_item = {17'd0, item.plan_value} < 32'(plan_count);
  assign ph_ok_item   = 32'(item.phase_number) < 32'(phase_count);
  assign run_ok       = {1'b0, running_plan} < (PI+1)'(plan_count);

  logic [SW-1:0] run_steps;
  assign run_steps = run_ok ? step_counts[running_plan] : '0;

  logic [PI-1:0] pslot_i;
  logic [HI-1:0] phslot_i;
  assign pslot_i  = PI'(item.plan_value);
  assign phslot_i = HI'(item.phase_number);

  logic [PI-1:0] scan_p;
  logic [MI-1:0] scan_m;
  assign scan_p = PI'(scan_idx);
  assign scan_m = MI'(scan_idx);

  logic [XW-1:0] scan_lim;
  always_comb begin
    if (ccmd == CMD_CHECK) begin
      scan_lim = XW'(move_counts[shown_phase]);
    end else begin
      scan_lim = XW'(plan_count);
    end
  end

  // Step memory address at the current position.
  logic [SA-1:0] step_addr;
  assign step_addr = SA'(32'(running_plan) * MAX_STEPS + 32'(step_position));

  logic [4:0] pos_inc;
  assign pos_inc = step_position + 5'd1;

  // The step read applies only when the plan, the step and its phase all exist.
  logic load_ok;
  assign load_ok = run_ok && (32'(step_position) < 32'(run_steps))
                 && (32'(rd_ph) < 32'(phase_count));

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur <= item;
      slot <= '0;
      allowed <= 1'b0;
      err <= ERR_OK;
      load_pend <= 1'b0;
      scan_pend <= 1'b0;
      mv_v <= 1'b0;
      best <= ID_CEILING;
      case (icmd)
        CMD_ADD_PLAN: begin
          if (32'(plan_count) >= MAX_PLANS) begin
            err <= ERR_FULL;
          end else begin
            slot <= 4'(plan_count);
            plan_ids[PI'(plan_count)] <= item.plan_value;
          end
        end
        CMD_ADD_STEP: begin
          if (!plan_ok_item) begin
            err <= ERR_NO_PLAN;
          end else if (!ph_ok_item) begin
            err <= ERR_NO_PHASE;
          end else if (32'(step_counts[pslot_i]) >= MAX_STEPS) begin
            err <= ERR_FULL;
          end else begin
            step_len_mem[SA'(32'(pslot_i) * MAX_STEPS + 32'(step_counts[pslot_i]))]
              <= length_in;
            step_ph_mem[SA'(32'(pslot_i) * MAX_STEPS + 32'(step_counts[pslot_i]))]
              <= phslot_i;
          end
        end
        CMD_ADD_PHASE: begin
          if (32'(phase_count) >= MAX_PHASES) begin
            err <= ERR_FULL;
          end else begin
            slot <= 4'(phase_count);
          end
        end
        CMD_ADD_MOVE: begin
          if (!ph_ok_item) begin
            err <= ERR_NO_PHASE;
          end else if (32'(move_counts[phslot_i]) >= MAX_MOVES) begin
            err <= ERR_FULL;
          end else begin
            move_mem[MA'(32'(phslot_i) * MAX_MOVES + 32'(move_counts[phslot_i]))]
              <= {item.from_set, item.to_set};
          end
        end
        CMD_BEGIN: begin
          scan_pend <= 1'b1;
          load_pend <= 1'b1;
        end
        CMD_TICK: begin
          if (ticks_left <= 17'd1) begin
            load_pend <= 1'b1;
          end
        end
        CMD_SET_PLAN: begin
          scan_pend <= 1'b1;
        end
        CMD_CHECK: begin
          if (32'(shown_phase) >= 32'(phase_count)) begin
            err <= ERR_NO_PHASE;
          end else begin
            scan_pend <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (ctl.scan_step) begin
      case (ccmd)
        CMD_BEGIN: begin
          if (scan_idx < scan_lim && plan_ids[scan_p] < best) begin
            best <= plan_ids[scan_p];
          end
        end
        CMD_CHECK: begin
          // The move table is read one entry per cycle; each entry is compared
          // in the cycle after its read.
          mv_rd <= move_mem[MA'(32'(shown_phase) * MAX_MOVES + 32'(scan_m))];
          mv_v  <= scan_idx < scan_lim;
          if (mv_v && mv_rd == key) begin
            allowed <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (ctl.load_req) begin
      rd_len <= step_len_mem[step_addr];
      rd_ph  <= step_ph_mem[step_addr];
    end else if (ctl.load_fin) begin
      if (!run_ok) begin
        err <= ERR_NO_PLAN;
      end else if (32'(step_position) >= 32'(run_steps)) begin
        err <= ERR_NO_STEP;
      end else if (32'(rd_ph) >= 32'(phase_count)) begin
        err <= ERR_NO_PHASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_clr) begin
      scan_idx <= '0;
    end else if (ctl.scan_step) begin
      scan_idx <= scan_idx + XW'(1);
    end
  end

  // Table counts and running state.
  always_ff @(posedge clk) begin
    if (rst) begin
      plan_count <= '0;
      phase_count <= '0;
      running_plan <= '0;
      shown_phase <= '0;
      step_position <= '0;
      ticks_left <= '0;
      for (int i = 0; i < MAX_PLANS; i++) step_counts[i] <= '0;
      for (int i = 0; i < MAX_PHASES; i++) move_counts[i] <= '0;
    end else if (ctl.capture) begin
      case (icmd)
        CMD_ADD_PLAN: begin
          if (32'(plan_count) < MAX_PLANS) begin
            step_counts[PI'(plan_count)] <= '0;
            plan_count <= plan_count + PW'(1);
          end
        end
        CMD_ADD_STEP: begin
          if (plan_ok_item && ph_ok_item && 32'(step_counts[pslot_i]) < MAX_STEPS) begin
            step_counts[pslot_i] <= step_counts[pslot_i] + SW'(1);
          end
        end
        CMD_ADD_PHASE: begin
          if (32'(phase_count) < MAX_PHASES) begin
            move_counts[HI'(phase_count)] <= '0;
            phase_count <= phase_count + HW'(1);
          end
        end
        CMD_ADD_MOVE: begin
          if (ph_ok_item && 32'(move_counts[phslot_i]) < MAX_MOVES) begin
            move_counts[phslot_i] <= move_counts[phslot_i] + MW'(1);
          end
        end
        CMD_BEGIN: begin
          running_plan <= '0;
          step_position <= '0;
        end
        CMD_TICK: begin
          if (ticks_left > 17'd1) begin
            ticks_left <= ticks_left - 17'd1;
          end else begin
            ticks_left <= '0;
            if (32'(pos_inc) < 32'(run_steps)) begin
              step_position <= pos_inc;
            end else begin
              step_position <= '0;
            end
          end
        end
        default: ;
      endcase
    end else if (ctl.scan_step) begin
      if (scan_idx < scan_lim) begin
        case (ccmd)
          CMD_BEGIN: begin
            if (plan_ids[scan_p] < best) running_plan <= scan_p;
          end
          CMD_SET_PLAN: begin
            if (plan_ids[scan_p] == cur.plan_value) running_plan <= scan_p;
          end
          default: ;
        endcase
      end
    end else if (ctl.load_fin) begin
      if (load_ok) begin
        shown_phase <= rd_ph;
        ticks_left <= rd_len;
      end
    end
  end

  assign sts.need_scan = scan_pend;
  assign sts.need_load = load_pend;
  // A move check needs one more scan step to compare the last entry read.
  assign sts.scan_done = (ccmd == CMD_CHECK) ? (scan_idx >= scan_lim)
                                             : ((scan_idx + XW'(1)) >= scan_lim);

  always_comb begin
    result.slot_index    = slot;
    result.allowed       = allowed;
    result.error         = err;
    result.current_plan  = 3'(running_plan);
    result.current_phase = 4'(shown_phase);
    result.current_step  = step_position;
    result.countdown     = ticks_left;
  end

endmodule

[hdl/ftsp_control.sv]
// Controller state machine of the signal plan sequencer.
// Depends on ftsp_pkg.
module ftsp_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  ftsp_pkg::sts_t sts,
  output ftsp_pkg::ctl_t ctl
);
  import ftsp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_READ   = 6'b001000,
    S_APPLY  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          ctl.scan_clr = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.need_scan) state_next = S_SCAN;
        else if (sts.need_load) state_next = S_READ;
        else state_next = S_DONE;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = sts.need_load ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        ctl.load_req = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        ctl.load_fin = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
